@@ rtl/rlz_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlz_pkg - shared types and constants
// Types, codes and constants of the run-length / back-reference decompressor.
// ---------------------------------------------------------------------------
package rlz_pkg;

	localparam int ADDR_BITS_DEF = 16;
	localparam int OUT_ADDR_W    = 16;
	localparam int LEN_W         = 11;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] END_BYTE  = 8'hFF;
	localparam logic [7:0] LONG_MASK = 8'hE0;
	localparam logic [7:0] SLEN_MASK = 8'h1F;
	localparam logic [7:0] LLEN_MASK = 8'h03;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_REFUSED = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CMD_COPY = 3'd0,
		CMD_FILL = 3'd1,
		CMD_ALT  = 3'd2,
		CMD_RAMP = 3'd3,
		CMD_ABS  = 3'd4,
		CMD_ABSX = 3'd5,
		CMD_REL  = 3'd6,
		CMD_RELX = 3'd7
	} cmd_t;

	typedef enum logic [5:0] {
		PH_CMD    = 6'b000001,
		PH_LENLO  = 6'b000010,
		PH_ARG1   = 6'b000100,
		PH_ARG2   = 6'b001000,
		PH_DIRECT = 6'b010000,
		PH_RUN    = 6'b100000
	} phase_t;

	// byte source for the back end
	typedef enum logic [1:0] {
		SRC_LIT   = 2'd0,
		SRC_STORE = 2'd1,
		SRC_NONE  = 2'd2
	} src_t;

	// one operation from the parser to the store stage
	typedef struct packed {
		kind_t                   kind;
		src_t                    src;
		logic [OUT_ADDR_W-1:0]   waddr;
		logic [OUT_ADDR_W-1:0]   raddr;
		logic [7:0]              lit;
		logic                    invert;
		logic                    pending;
	} op_t;

endpackage

@@ rtl/rlz_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlz_in_if / rlz_out_if - stream channels
// Valid/ready channels for compressed input items and decoded results.
// ---------------------------------------------------------------------------
interface rlz_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_byte;
	modport source (output valid, output req_type, output in_byte, input ready);
	modport sink (input valid, input req_type, input in_byte, output ready);
endinterface

interface rlz_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [15:0] out_addr;
	logic [7:0]  out_byte;
	logic        run_pending;
	modport source (output valid, output out_kind, output out_addr, output out_byte,
		output run_pending, input ready);
	modport sink (input valid, input out_kind, input out_addr, input out_byte,
		input run_pending, output ready);
endinterface

@@ rtl/rle_lz_stream_decompressor_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rle_lz_stream_decompressor_core - command stream decompressor
// Expands literal copy, run-length, fill, ramp and back-reference commands into a
// 2**ADDR_BITS byte output store and reports every byte written.
// ---------------------------------------------------------------------------
// Usage:
//  in  : req_type 0 = compressed byte, 1 = tick for the next run byte.
//  out : one result per data byte, end marker (0xFF) or refused source byte.
//  cfg : cfg_we/cfg_data load output_base and restart the stream; write
//        only while idle.
// One item is accepted per cycle while the queue has room. After its item
// transfer, a result passes through the queue write, the store read and the
// output register. The memory bypass covers back-references one byte
// behind the write position.
// Items causing no result produce no op and take no queue slot.
// If the receiver stalls, the output register, stage 1 and the two-entry
// queue fill and in.ready drops; nothing is lost. Reset clears all control
// state and sets output_base to zero; the store contents stay undefined
// until written.
// ---------------------------------------------------------------------------
module rle_lz_stream_decompressor_core #(
	parameter int ADDR_BITS = rlz_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	rlz_in_if.sink      in,
	rlz_out_if.source   out
);
	import rlz_pkg::*;

	logic in_fire;
	logic op_valid;
	op_t  op;
	logic q_ne, q_nf, q_pop;
	op_t  q_head;

	assign in.ready = q_nf;
	assign in_fire  = in.valid && in.ready;

	rlz_parser #(.ADDR_BITS(ADDR_BITS)) u_parser (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_fire,
		.req_type(in.req_type), .in_byte(in.in_byte),
		.op_valid, .op
	);

	rlz_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push(op_valid), .push_data(op), .pop(q_pop),
		.not_empty(q_ne), .not_full(q_nf), .head(q_head)
	);

	rlz_store #(.ADDR_BITS(ADDR_BITS)) u_store (
		.clk, .arst_n, .op_avail(q_ne), .op(q_head), .op_take(q_pop), .out(out)
	);

endmodule

@@ rtl/rlz_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlz_parser - front end
// Parses headers and arguments, tracks run state and issues one store
// operation per data byte, end marker or refusal.
// ---------------------------------------------------------------------------
module rlz_parser #(
	parameter int ADDR_BITS = rlz_pkg::ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               in_fire,
	input  logic               req_type,
	input  logic [7:0]         in_byte,
	output logic               op_valid,
	output rlz_pkg::op_t       op
);
	import rlz_pkg::*;

	phase_t                 phase_q;
	cmd_t                   cmd_q;
	logic [LEN_W-1:0]       len_q;
	logic [15:0]            pair_q;
	logic                   tog_q;
	logic [15:0]            base_q;
	logic [ADDR_BITS-1:0]   wpos_q;
	logic [ADDR_BITS-1:0]   rpos_q;

	phase_t                 phase_d;
	cmd_t                   cmd_d;
	logic [LEN_W-1:0]       len_d;
	logic [15:0]            pair_d;
	logic                   tog_d;
	logic [ADDR_BITS-1:0]   wpos_d;
	logic [ADDR_BITS-1:0]   rpos_d;
	logic                   emit_run;
	logic [ADDR_BITS-1:0]   rsel;
	logic [LEN_W-1:0]       len_dec;

	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		pair_d   = pair_q;
		tog_d    = tog_q;
		wpos_d   = wpos_q;
		rpos_d   = rpos_q;
		emit_run = 1'b0;
		rsel     = rpos_q;
		op_valid = 1'b0;
		op       = '0;
		op.kind  = KIND_DATA;
		op.src   = SRC_NONE;
		len_dec  = '0;
		if (in_fire) begin
			if (req_type) begin
				emit_run = (phase_q == PH_RUN);
			end else begin
				unique case (phase_q)
					PH_CMD: begin
						if (in_byte == END_BYTE) begin
							wpos_d   = base_q[ADDR_BITS-1:0];
							op_valid = 1'b1;
							op.kind  = KIND_END;
						end else if ((in_byte & LONG_MASK) == LONG_MASK) begin
							cmd_d   = cmd_t'(in_byte[4:2]);
							len_d   = {1'b0, in_byte[1:0], 8'h00};
							phase_d = PH_LENLO;
						end else begin
							cmd_d   = cmd_t'(in_byte[7:5]);
							len_d   = LEN_W'(in_byte & SLEN_MASK) + LEN_W'(1);
							phase_d = (cmd_t'(in_byte[7:5]) == CMD_COPY) ? PH_DIRECT : PH_ARG1;
							tog_d   = 1'b0;
						end
					end
					PH_LENLO: begin
						len_d   = (len_q | LEN_W'(in_byte)) + LEN_W'(1);
						phase_d = (cmd_q == CMD_COPY) ? PH_DIRECT : PH_ARG1;
						tog_d   = 1'b0;
					end
					PH_DIRECT: begin
						len_d    = len_q - LEN_W'(1);
						if (len_d == '0) phase_d = PH_CMD;
						op_valid = 1'b1;
						op.src   = SRC_LIT;
						op.lit   = in_byte;
						op.waddr = OUT_ADDR_W'(wpos_q);
						wpos_d   = wpos_q + 1'b1;
					end
					PH_ARG1: begin
						unique case (cmd_q)
							CMD_ALT, CMD_ABS, CMD_ABSX: begin
								pair_d  = {8'h00, in_byte};
								phase_d = PH_ARG2;
							end
							CMD_REL, CMD_RELX: begin
								rsel     = wpos_q - ADDR_BITS'(in_byte);
								emit_run = 1'b1;
							end
							default: begin
								pair_d   = {in_byte, in_byte};
								emit_run = 1'b1;
							end
						endcase
					end
					PH_ARG2: begin
						pair_d = {in_byte, pair_q[7:0]};
						if (cmd_q != CMD_ALT)
							rsel = ADDR_BITS'({in_byte, pair_q[7:0]} + base_q);
						emit_run = 1'b1;
					end
					PH_RUN: begin
						op_valid    = 1'b1;
						op.kind     = KIND_REFUSED;
						op.pending  = 1'b1;
					end
					default: phase_d = PH_CMD;
				endcase
			end
		end
		if (emit_run) begin
			// pair_d carries any argument loaded this cycle
			op_valid  = 1'b1;
			op.waddr  = OUT_ADDR_W'(wpos_q);
			op.raddr  = OUT_ADDR_W'(rsel);
			wpos_d    = wpos_q + 1'b1;
			op.src    = SRC_LIT;
			case (cmd_q)
				CMD_FILL: op.lit = pair_d[7:0];
				CMD_ALT: begin
					op.lit = tog_q ? pair_d[15:8] : pair_d[7:0];
					tog_d  = ~tog_q;
				end
				CMD_RAMP: begin
					op.lit = pair_d[7:0];
					pair_d = {pair_d[15:8], pair_d[7:0] + 8'd1};
				end
				default: begin
					op.src    = SRC_STORE;
					op.invert = cmd_q[0];
					rpos_d    = rsel + 1'b1;
				end
			endcase
			len_dec    = (len_q != '0) ? len_q - LEN_W'(1) : len_q;
			len_d      = len_dec;
			phase_d    = (len_dec == '0) ? PH_CMD : PH_RUN;
			op.pending = (len_dec != '0);
		end
		if (cfg_we) begin
			wpos_d  = cfg_data[ADDR_BITS-1:0];
			phase_d = PH_CMD;
			len_d   = '0;
			tog_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			cmd_q   <= CMD_COPY;
			len_q   <= '0;
			pair_q  <= '0;
			tog_q   <= 1'b0;
			base_q  <= '0;
			wpos_q  <= '0;
			rpos_q  <= '0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			pair_q  <= pair_d;
			tog_q   <= tog_d;
			wpos_q  <= wpos_d;
			rpos_q  <= rpos_d;
			if (cfg_we) base_q <= cfg_data;
		end
	end

endmodule

@@ rtl/rlz_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlz_queue - operation queue
// Small FIFO between the parser and the store stage.
// ---------------------------------------------------------------------------
module rlz_queue #(
	parameter int DEPTH = rlz_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rlz_pkg::op_t  push_data,
	input  logic          pop,
	output logic          not_empty,
	output logic          not_full,
	output rlz_pkg::op_t  head
);
	import rlz_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign not_empty = (cnt_q != '0);
	assign not_full  = (cnt_q != (PW+1)'(DEPTH));
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

@@ rtl/rlz_store.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlz_store - back end
// Output store with registered read. Stage 1 reads/writes the memory
// and forms the byte, stage 2 holds the result for the receiver.
// ---------------------------------------------------------------------------
module rlz_store #(
	parameter int ADDR_BITS = rlz_pkg::ADDR_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_avail,
	input  rlz_pkg::op_t  op,
	output logic          op_take,
	rlz_out_if.source     out
);
	import rlz_pkg::*;

	logic [7:0]           mem [2**ADDR_BITS];
	logic [7:0]           rd_s1;
	logic                 fwd_s1;
	logic [7:0]           fwd_byte_s1;
	op_t                  op_s1;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 adv;

	// stage 1 holds the op whose memory read is in flight; its result goes
	// straight to the output register, so stage 1 advances when out frees
	assign adv     = !out.valid || out.ready;
	assign op_take = op_avail && adv;

	// stored value, with bypass of the write landing on the same edge as the read
	always_comb begin
		byte_s1 = fwd_s1 ? fwd_byte_s1 : rd_s1;
		if (op_s1.invert) byte_s1 = ~byte_s1;
		if (op_s1.src != SRC_STORE) byte_s1 = op_s1.lit;
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			rd_s1       <= mem[op.raddr[ADDR_BITS-1:0]];
			op_s1       <= op;
			fwd_s1      <= valid_s1 && (op_s1.kind == KIND_DATA) &&
				(op_s1.waddr[ADDR_BITS-1:0] == op.raddr[ADDR_BITS-1:0]);
			fwd_byte_s1 <= byte_s1;
		end
		if (valid_s1 && adv && op_s1.kind == KIND_DATA)
			mem[op_s1.waddr[ADDR_BITS-1:0]] <= byte_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out.valid <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1  <= op_take;
				out.valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out.out_kind    <= op_s1.kind;
			out.out_addr    <= (op_s1.kind == KIND_DATA) ? op_s1.waddr : '0;
			out.out_byte    <= (op_s1.kind == KIND_DATA) ? byte_s1 : 8'h00;
			out.run_pending <= op_s1.pending;
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - decompressor stream check
// Feeds command streams and ticks into the decompressor, predicts every
// written byte, end marker and refusal, and compares results in order.
// ---------------------------------------------------------------------------
module tb;
	import rlz_pkg::*;

	typedef struct packed {
		logic       tick;
		logic [7:0] b;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        pend;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_data = '0;

	rlz_in_if  in_ch();
	rlz_out_if out_ch();

	rle_lz_stream_decompressor_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in(in_ch.sink), .out(out_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [7:0]  mem [0:65535];
	logic [15:0] base_q, wpos, rpos, pair;
	phase_t      ph;
	cmd_t        cmd;
	logic [10:0] rlen;
	logic        alt;

	req_t pending_reqs[$];
	res_t expected_res[$];
	int   errors = 0;
	bit   calm = 1'b0;
	bit   hold_out = 1'b0;
	bit   in_held = 1'b0;

	function automatic res_t put_byte(logic [7:0] v, logic p);
		res_t r;
		r.kind = KIND_DATA; r.addr = wpos; r.data = v; r.pend = p;
		mem[wpos] = v;
		wpos++;
		return r;
	endfunction

	function automatic res_t run_byte();
		logic [7:0] v;
		case (cmd)
			CMD_FILL: v = pair[7:0];
			CMD_ALT: begin
				v = alt ? pair[15:8] : pair[7:0];
				alt = ~alt;
			end
			CMD_RAMP: begin
				v = pair[7:0];
				pair[7:0] = v + 8'd1;
			end
			default: begin
				v = mem[rpos];
				rpos++;
				if (cmd[0]) v = ~v;
			end
		endcase
		if (rlen != 0) rlen--;
		ph = (rlen == 0) ? PH_CMD : PH_RUN;
		return put_byte(v, rlen != 0);
	endfunction

	function automatic void load_base(logic [15:0] v);
		base_q = v; wpos = v; ph = PH_CMD; rlen = 0; alt = 1'b0;
	endfunction

	function automatic void after_len();
		ph = (cmd == CMD_COPY) ? PH_DIRECT : PH_ARG1;
		alt = 1'b0;
	endfunction

	// returns 1 with a result in r when the item causes one
	function automatic bit decode_step(req_t q, output res_t r);
		r = '0;
		if (q.tick) begin
			if (ph != PH_RUN) return 1'b0;
			r = run_byte();
			return 1'b1;
		end
		case (ph)
			PH_CMD: begin
				if (q.b == END_BYTE) begin
					wpos = base_q;
					r.kind = KIND_END;
					return 1'b1;
				end
				if ((q.b & LONG_MASK) == LONG_MASK) begin
					cmd = cmd_t'(q.b[4:2]);
					rlen = {1'b0, q.b[1:0], 8'h00};
					ph = PH_LENLO;
				end else begin
					cmd = cmd_t'(q.b[7:5]);
					rlen = {6'd0, q.b[4:0]} + 11'd1;
					after_len();
				end
				return 1'b0;
			end
			PH_LENLO: begin
				rlen = (rlen | {3'd0, q.b}) + 11'd1;
				after_len();
				return 1'b0;
			end
			PH_DIRECT: begin
				rlen--;
				if (rlen == 0) ph = PH_CMD;
				r = put_byte(q.b, 1'b0);
				return 1'b1;
			end
			PH_ARG1: begin
				case (cmd)
					CMD_ALT, CMD_ABS, CMD_ABSX: begin
						pair = {8'd0, q.b};
						ph = PH_ARG2;
						return 1'b0;
					end
					CMD_REL, CMD_RELX: rpos = wpos - {8'd0, q.b};
					default: pair = {q.b, q.b};
				endcase
				r = run_byte();
				return 1'b1;
			end
			PH_ARG2: begin
				if (cmd != CMD_ALT) rpos = {q.b, pair[7:0]} + base_q;
				pair[15:8] = q.b;
				r = run_byte();
				return 1'b1;
			end
			default: begin
				r.kind = KIND_REFUSED; r.pend = 1'b1;
				return 1'b1;
			end
		endcase
	endfunction

	// stream generation: a shadow copy of the write position decides legal refs
	logic [15:0] g_wpos, g_base;
	bit          g_ok [0:65535];

	task automatic push(bit tick, logic [7:0] b);
		req_t q;
		q.tick = tick; q.b = b;
		pending_reqs.push_back(q);
	endtask

	task automatic gen_ticks(int n, bit noise);
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 15) == 0) push(1'b0, 8'($urandom));
			push(1'b1, 8'($urandom));
		end
	endtask

	// one command of code c, length len (1..1024), random content
	task automatic gen_cmd(cmd_t c, int len, bit noise);
		logic [9:0] l;
		logic [15:0] src;
		logic [15:0] span;
		int d;
		l = 10'(len - 1);
		span = g_wpos - g_base;
		// a short header of code 7 would read as a long header
		if (len <= 32 && $urandom_range(0, 3) != 0 && c != CMD_RELX)
			push(1'b0, {c, l[4:0]});
		else begin
			push(1'b0, {3'b111, c, l[9:8]});
			push(1'b0, l[7:0]);
		end
		case (c)
			CMD_COPY: begin
				for (int i = 0; i < len; i++) begin
					push(1'b0, 8'($urandom));
					g_ok[g_wpos++] = 1'b1;
				end
				return;
			end
			CMD_FILL, CMD_RAMP: push(1'b0, 8'($urandom));
			CMD_ALT: begin push(1'b0, 8'($urandom)); push(1'b0, 8'($urandom)); end
			CMD_ABS, CMD_ABSX: begin
				src = g_base + 16'($urandom_range(0, 15));
				if (!g_ok[src] || 16'(src - g_base) >= span) src = g_wpos - 16'd1;
				src = src - g_base;
				push(1'b0, src[7:0]); push(1'b0, src[15:8]);
			end
			default: begin
				d = $urandom_range(1, 255);
				if (!g_ok[g_wpos - d[15:0]] || d > int'(span)) d = 1;
				push(1'b0, d[7:0]);
			end
		endcase
		g_ok[g_wpos++] = 1'b1;
		// each read stays inside what is written, since runs only move forward
		for (int i = 1; i < len; i++) g_ok[g_wpos + 16'(i) - 16'd1] = 1'b1;
		gen_ticks(len - 1, noise);
		g_wpos += 16'(len - 1);
	endtask

	task automatic gen_stream(int ncmd, bit noise);
		cmd_t c;
		int len;
		for (int i = 0; i < ncmd; i++) begin
			c = cmd_t'($urandom_range(0, 7));
			if (c >= CMD_ABS && g_wpos == g_base) c = CMD_COPY;
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 96)
				: $urandom_range(1, 12);
			gen_cmd(c, len, noise);
		end
		push(1'b0, END_BYTE);
		g_wpos = g_base;
	endtask

	task automatic set_base(logic [15:0] v);
		while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		g_base = v; g_wpos = v;
		load_base(v);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_held) begin
				// hold the offered item
			end else if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
				in_ch.valid <= 1'b1;
				in_ch.req_type <= pending_reqs[0].tick;
				in_ch.in_byte <= pending_reqs[0].b;
			end else begin
				in_ch.valid <= 1'b0;
				in_ch.req_type <= 1'($urandom);
				in_ch.in_byte <= 8'($urandom);
			end
			out_ch.ready <= !hold_out && (calm || $urandom_range(0, 99) >= 38);
		end
	end

	// monitor
	always @(posedge clk) begin
		req_t q;
		res_t r, e, got;
		in_held = arst_n && in_ch.valid && !in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			q = pending_reqs.pop_front();
			if (decode_step(q, r)) expected_res.push_back(r);
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.out_kind, out_ch.out_addr, out_ch.out_byte, out_ch.run_pending};
			if (expected_res.size() == 0) begin
				$error("unexpected result kind=%0d addr=%h", got.kind, got.addr);
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (got.kind !== e.kind) begin
					$error("out_kind exp %0d got %0d", e.kind, got.kind); errors++;
				end
				if (got.addr !== e.addr) begin
					$error("out_addr exp %h got %h", e.addr, got.addr); errors++;
				end
				if (got.data !== e.data) begin
					$error("out_byte exp %h got %h", e.data, got.data); errors++;
				end
				if (got.pend !== e.pend) begin
					$error("run_pending exp %0d got %0d", e.pend, got.pend); errors++;
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0; in_ch.req_type = 1'b0; in_ch.in_byte = '0;
		out_ch.ready = 1'b0;
		load_base(16'h0000);
		rpos = '0; pair = '0; cmd = CMD_COPY;
		g_base = 0; g_wpos = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: every command, both header forms, refusal, idle tick, end
		push(1'b1, 8'h00);
		gen_cmd(CMD_COPY, 3, 1'b0);
		push(1'b0, 8'h01); push(1'b0, 8'h00); push(1'b0, 8'hFF);
		push(1'b0, {CMD_FILL, 5'd2}); push(1'b0, 8'hA5); push(1'b0, 8'h3C);
		gen_ticks(2, 1'b0);
		gen_cmd(CMD_ALT, 4, 1'b0);
		push(1'b0, {3'b111, CMD_RAMP, 2'b00}); push(1'b0, 8'h03); push(1'b0, 8'hFE);
		gen_ticks(3, 1'b0);
		gen_cmd(CMD_ABS, 5, 1'b0);
		gen_cmd(CMD_ABSX, 2, 1'b0);
		gen_cmd(CMD_REL, 6, 1'b0);
		gen_cmd(CMD_RELX, 3, 1'b0);
		push(1'b0, END_BYTE);
		push(1'b1, 8'hFF);
		// longest fill across the top of the store, cut short by a restart
		set_base(16'hFFF8);
		push(1'b0, {3'b111, CMD_FILL, 2'b11}); push(1'b0, 8'hFF); push(1'b0, 8'h5A);
		gen_ticks(12, 1'b0);
		set_base(16'hFFFF);
		gen_stream(4, 1'b1);

		// random streams; a hold-off fills the pipe
		set_base(16'($urandom));
		fork
			begin
				repeat (60) @(posedge clk);
				hold_out = 1'b1;
				repeat (200) @(posedge clk);
				hold_out = 1'b0;
			end
		join_none
		gen_stream(18, 1'b1);
		set_base(16'($urandom));
		calm = 1'b1;
		gen_stream(8, 1'b0);
		set_base(16'($urandom));
		calm = 1'b0;
		gen_stream(18, 1'b1);

		while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
